FILE: rtl/iskl_pkg.sv
// Package of the info string key lookup: types, codes and shared constants.
package iskl_pkg;

  localparam int MAX_KEY_LEN  = 32;
  localparam int COUNT_WIDTH  = 16;
  localparam int KEY_POS_W    = 6;
  localparam int KEY_WORDS    = 4;
  localparam int KEY_WORD_W   = 64;
  localparam int MAX_LEN_W    = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int CMP_W        = (COUNT_WIDTH > MAX_LEN_W) ? COUNT_WIDTH : MAX_LEN_W;

  localparam logic [7:0] SEP_CHAR = 8'h5C;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(8192);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS_A     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS_B     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS_C     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS_D     = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INFO_LENGTH = CFG_IDX_W'(5);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } iskl_phase_e;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_OVERSIZE  = 2'd2
  } iskl_status_e;

  typedef logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] iskl_key_t;

  typedef struct packed {
    iskl_phase_e            phase;
    logic [KEY_POS_W-1:0]   key_pos;
    logic                   key_still;
    logic                   val_sel;
    logic                   key_found;
    logic [COUNT_WIDTH-1:0] byte_cnt;
  } iskl_state_t;

  typedef struct packed {
    logic [7:0]   value_byte;
    logic         is_end;
    iskl_status_e status;
  } iskl_result_t;

  function automatic iskl_state_t iskl_clear_state();
    iskl_state_t s;
    s.phase     = PH_START;
    s.key_pos   = '0;
    s.key_still = 1'b1;
    s.val_sel   = 1'b0;
    s.key_found = 1'b0;
    s.byte_cnt  = '0;
    return s;
  endfunction

  function automatic logic [7:0] iskl_fold(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
  endfunction

endpackage

FILE: rtl/iskl_intf.sv
// Stream interfaces of the info string key lookup: string bytes in, results out.
interface iskl_in_if;
  import iskl_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface iskl_out_if;
  import iskl_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       is_end;
  logic [1:0] status;
  modport source (output valid, output value_byte, output is_end, output status, input ready);
  modport sink   (input valid, input value_byte, input is_end, input status, output ready);
endinterface

FILE: rtl/iskl_step.sv
// Next-state and result logic for one string byte.
module iskl_step
  import iskl_pkg::*;
(
  input  iskl_state_t          st_i,
  input  logic [7:0]           ch_i,
  input  logic [KEY_POS_W-1:0] key_len_i,
  input  iskl_key_t            key_chars_i,
  input  logic [MAX_LEN_W-1:0] max_len_i,
  output iskl_state_t          st_o,
  output logic                 res_vld_o,
  output iskl_result_t         res_o
);

  localparam logic [KEY_POS_W-1:0] KEY_MAX = KEY_POS_W'(MAX_KEY_LEN);

  logic                 is_sep;
  logic                 len_bad;
  logic [KEY_POS_W-1:0] kc_pos;
  logic                 kc_still;
  logic [4:0]           kc_idx;
  logic [7:0]           kc_key;
  logic                 kc_still_n;
  logic [KEY_POS_W-1:0] kc_pos_n;
  logic                 key_match;

  assign is_sep  = (ch_i == SEP_CHAR);
  assign len_bad = (key_len_i > KEY_MAX);

  // one key character step; a new key starts from position zero
  assign kc_pos   = (st_i.phase == PH_START) ? '0 : st_i.key_pos;
  assign kc_still = (st_i.phase == PH_START) ? 1'b1 : st_i.key_still;
  assign kc_idx   = kc_pos[4:0];
  assign kc_key   = key_chars_i[kc_idx[4:3]][kc_idx[2:0]*8 +: 8];
  assign kc_pos_n = (kc_pos != '1) ? kc_pos + KEY_POS_W'(1) : kc_pos;

  always_comb begin
    kc_still_n = kc_still;
    if (kc_still) begin
      if (len_bad || kc_pos >= key_len_i) begin
        kc_still_n = 1'b0;
      end else if (kc_key == 8'h00 || iskl_fold(kc_key) != iskl_fold(ch_i)) begin
        kc_still_n = 1'b0;
      end
    end
  end

  assign key_match = st_i.key_still && !len_bad && (st_i.key_pos == key_len_i);

  always_comb begin
    st_o      = st_i;
    res_vld_o = 1'b0;
    res_o     = '{value_byte: 8'h00, is_end: 1'b0, status: ST_FOUND};
    if (ch_i == 8'h00) begin
      res_vld_o    = 1'b1;
      res_o.is_end = 1'b1;
      if (CMP_W'(st_i.byte_cnt) >= CMP_W'(max_len_i)) begin
        res_o.status = ST_OVERSIZE;
      end else if (st_i.key_found) begin
        res_o.status = ST_FOUND;
      end else begin
        res_o.status = ST_NOT_FOUND;
      end
      st_o = iskl_clear_state();
    end else begin
      if (st_i.byte_cnt != '1) begin
        st_o.byte_cnt = st_i.byte_cnt + COUNT_WIDTH'(1);
      end
      unique case (st_i.phase)
        PH_START: begin
          st_o.phase     = PH_KEY;
          st_o.key_pos   = '0;
          st_o.key_still = 1'b1;
          if (!is_sep) begin
            st_o.key_pos   = kc_pos_n;
            st_o.key_still = kc_still_n;
          end
        end
        PH_KEY: begin
          if (is_sep) begin
            st_o.val_sel = key_match;
            if (key_match) begin
              st_o.key_found = 1'b1;
            end
            st_o.phase = PH_VALUE;
          end else begin
            st_o.key_pos   = kc_pos_n;
            st_o.key_still = kc_still_n;
          end
        end
        PH_VALUE: begin
          if (is_sep) begin
            if (st_i.val_sel) begin
              st_o.val_sel = 1'b0;
              st_o.phase   = PH_DONE;
            end else begin
              st_o.key_pos   = '0;
              st_o.key_still = 1'b1;
              st_o.phase     = PH_KEY;
            end
          end else if (st_i.val_sel) begin
            res_vld_o        = 1'b1;
            res_o.value_byte = ch_i;
          end
        end
        PH_DONE: begin
          st_o.phase = PH_DONE;
        end
        default: begin
          st_o.phase = PH_DONE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/info_string_key_lookup_core.sv
// Info string key lookup: top level with config registers, byte and result stages.
//
// Scans a backslash-separated key/value info string, one byte per transaction on
// in_i, and looks up the key programmed in the config registers (ASCII case is
// ignored). Each value byte of the first matching key comes out on out_o as a
// transaction with is_end low; the zero byte that ends the string produces one
// transaction with is_end high and status found, not found or oversize. Oversize
// is only known at the terminator, so on that status the value bytes already
// delivered must be thrown away. Throughput is one byte per cycle while results
// are taken: a byte enters the input register, the key compare and the state
// update run between that register and the result register, and a byte with a
// result waits while the result register is held. Bytes that make no result
// (keys, separators, unselected values) never wait for the output side. The
// longest path is the key character select, case fold and compare in iskl_step.
// The user must write config registers only while no string byte is in flight;
// the block does not enforce this. A write does not touch the scan state.
module info_string_key_lookup_core
  import iskl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  iskl_in_if.sink               in_i,
  iskl_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // config registers
  logic [KEY_POS_W-1:0] key_len_q;
  iskl_key_t            key_chars_q;
  logic [MAX_LEN_W-1:0] max_len_q;

  // scan state
  iskl_state_t st_q;
  iskl_state_t st_d;

  // input stage
  logic       s1_vld_q;
  logic [7:0] ch_q;

  // result stage
  logic         out_vld_q;
  iskl_result_t out_res_q;

  logic         res_vld;
  iskl_result_t res;
  logic         out_free;
  logic         s1_adv;
  logic         in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q   <= '0;
      key_chars_q <= '0;
      max_len_q   <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_LENGTH:      key_len_q      <= cfg_wdata_i[KEY_POS_W-1:0];
        REG_KEY_CHARS_A:     key_chars_q[0] <= cfg_wdata_i;
        REG_KEY_CHARS_B:     key_chars_q[1] <= cfg_wdata_i;
        REG_KEY_CHARS_C:     key_chars_q[2] <= cfg_wdata_i;
        REG_KEY_CHARS_D:     key_chars_q[3] <= cfg_wdata_i;
        REG_MAX_INFO_LENGTH: max_len_q      <= cfg_wdata_i[MAX_LEN_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  iskl_step u_step (
    .st_i        (st_q),
    .ch_i        (ch_q),
    .key_len_i   (key_len_q),
    .key_chars_i (key_chars_q),
    .max_len_i   (max_len_q),
    .st_o        (st_d),
    .res_vld_o   (res_vld),
    .res_o       (res)
  );

  // A byte leaves the input stage unless it has a result and the result
  // register is still held by the sink.
  assign out_free   = !out_vld_q || out_o.ready;
  assign s1_adv     = s1_vld_q && (!res_vld || out_free);
  assign in_i.ready = !s1_vld_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= iskl_clear_state();
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        st_q <= st_d;
      end
      if (s1_adv && res_vld) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q <= in_i.ch;
    end
    if (s1_adv && res_vld) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.value_byte = out_res_q.value_byte;
  assign out_o.is_end     = out_res_q.is_end;
  assign out_o.status     = out_res_q.status;

endmodule

FILE: rtl/iskl_checker.sv
// Port checker of the info string key lookup, bound to the top level.
module iskl_checker
  import iskl_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] value_byte_i,
  input logic       is_end_i,
  input logic [1:0] status_i
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(value_byte_i) &&
                                    $stable(is_end_i) && $stable(status_i))
    else $error("result changed while stalled");

  a_end_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_end_i |-> value_byte_i == 8'h00)
    else $error("end result carries a value byte");

  a_end_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_end_i |->
      status_i == ST_FOUND || status_i == ST_NOT_FOUND || status_i == ST_OVERSIZE)
    else $error("undefined end status");

  // value bytes only ever come from a matched key and are never zero
  a_value_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_end_i |-> status_i == ST_FOUND && value_byte_i != 8'h00 &&
                                 value_byte_i != SEP_CHAR)
    else $error("malformed value byte result");

endmodule

bind info_string_key_lookup_core iskl_checker u_iskl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .value_byte_i (out_o.value_byte),
  .is_end_i     (out_o.is_end),
  .status_i     (out_o.status)
);

FILE: tb/sv/info_string_key_lookup_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of info_string_key_lookup_core: directed and random info strings.
module info_string_key_lookup_core_test;
  import iskl_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 7;
  localparam int QUIET_LIMIT  = 1000;   // cycles without any transaction before giving up
  localparam int DRAIN_CYCLES = 4;      // lets the input and result registers empty after the last result, with margin
  localparam int RANDOM_BYTES = 1890;
  localparam int SETTING_BYTES = 150;   // bytes per random register setting

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [MAX_LEN_W-1:0]   MAX_LEN_TOP = '1;

  // Indexes the block has no register behind
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_HI = CFG_IDX_W'(7);

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  iskl_in_if  in_if ();
  iskl_out_if out_if ();

  info_string_key_lookup_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow registers and scan state of the lookup predictor
  // ---------------------------------------------------------------------------
  logic [KEY_POS_W-1:0]   key_len_sh  = '0;
  iskl_key_t              key_words_sh = '0;
  logic [MAX_LEN_W-1:0]   max_len_sh  = MAX_LEN_RESET;

  iskl_phase_e            phase_sh     = PH_START;
  logic [KEY_POS_W-1:0]   key_pos_sh   = '0;
  logic                   key_still_sh = 1'b1;
  logic                   val_sel_sh   = 1'b0;
  logic                   found_sh     = 1'b0;
  logic [COUNT_WIDTH-1:0] byte_cnt_sh  = '0;

  // Value bytes and end statuses the block still owes us, oldest first
  iskl_result_t lookup_results_q[$];

  int errors          = 0;
  int strings_sent    = 0;
  int bytes_sent      = 0;
  int results_checked = 0;
  int settings_used   = 0;
  int status_seen[3]  = '{0, 0, 0};

  bit idle_en     = 1'b1;   // random gaps and stalls on both sides
  int stall_left  = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] key_char_at(input logic [4:0] p);
    return key_words_sh[p[4:3]][{p[2:0], 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
  endfunction

  // Append one expected result at the tail of the queue
  task automatic queue_result(input iskl_result_t r);
    lookup_results_q.insert(lookup_results_q.size(), r);
  endtask

  task automatic clear_scan();
    phase_sh     = PH_START;
    key_pos_sh   = '0;
    key_still_sh = 1'b1;
    val_sel_sh   = 1'b0;
    found_sh     = 1'b0;
    byte_cnt_sh  = '0;
  endtask

  task automatic start_key();
    key_pos_sh   = '0;
    key_still_sh = 1'b1;
  endtask

  // One key character: the key stays a candidate only while it equals the
  // configured prefix, case folded; a zero in the configured key never matches.
  task automatic compare_key_char(input logic [7:0] c);
    logic [7:0] k;
    if (key_still_sh) begin
      if (key_len_sh > MAX_KEY_LEN || key_pos_sh >= key_len_sh) begin
        key_still_sh = 1'b0;
      end else begin
        k = key_char_at(key_pos_sh[4:0]);
        if (k == 8'h00 || upcase(k) != upcase(c)) begin
          key_still_sh = 1'b0;
        end
      end
    end
    if (key_pos_sh != '1) begin
      key_pos_sh++;
    end
  endtask

  function automatic logic key_complete();
    return key_still_sh && key_len_sh <= MAX_KEY_LEN && key_pos_sh == key_len_sh;
  endfunction

  // Advance the shadow scan by one accepted byte and queue what it must produce
  task automatic scan_byte(input logic [7:0] c);
    iskl_result_t r;
    if (c == 8'h00) begin
      r.value_byte = 8'h00;
      r.is_end     = 1'b1;
      // oversize wins over found
      if (byte_cnt_sh >= max_len_sh) begin
        r.status = ST_OVERSIZE;
      end else if (found_sh) begin
        r.status = ST_FOUND;
      end else begin
        r.status = ST_NOT_FOUND;
      end
      queue_result(r);
      clear_scan();
      return;
    end
    if (byte_cnt_sh != COUNT_MAX) begin
      byte_cnt_sh++;
    end
    case (phase_sh)
      PH_START: begin
        // one leading separator is swallowed
        start_key();
        phase_sh = PH_KEY;
        if (c != SEP_CHAR) begin
          compare_key_char(c);
        end
      end
      PH_KEY: begin
        if (c == SEP_CHAR) begin
          if (key_complete()) begin
            found_sh   = 1'b1;
            val_sel_sh = 1'b1;
          end else begin
            val_sel_sh = 1'b0;
          end
          phase_sh = PH_VALUE;
        end else begin
          compare_key_char(c);
        end
      end
      PH_VALUE: begin
        if (c == SEP_CHAR) begin
          if (val_sel_sh) begin
            val_sel_sh = 1'b0;
            phase_sh   = PH_DONE;
          end else begin
            start_key();
            phase_sh = PH_KEY;
          end
        end else if (val_sel_sh) begin
          r.value_byte = c;
          r.is_end     = 1'b0;
          r.status     = ST_FOUND;
          queue_result(r);
        end
      end
      default: begin
        // late bytes only count toward the length
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY_LENGTH:      key_len_sh = data[KEY_POS_W-1:0];
      REG_KEY_CHARS_A:     key_words_sh[0] = data;
      REG_KEY_CHARS_B:     key_words_sh[1] = data;
      REG_KEY_CHARS_C:     key_words_sh[2] = data;
      REG_KEY_CHARS_D:     key_words_sh[3] = data;
      REG_MAX_INFO_LENGTH: max_len_sh = data[MAX_LEN_W-1:0];
      default: ;
    endcase
    settings_used++;
  endtask

  // Sends one string byte; valid stays up after the transaction so that a
  // back-to-back byte follows without a bubble.
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = idle_en ? $urandom_range(0, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    scan_byte(c);
    bytes_sent++;
    if (c == 8'h00) begin
      strings_sent++;
    end
  endtask

  task automatic send_text(input string s, input bit terminate);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
    if (terminate) begin
      send_byte(8'h00);
    end
  endtask

  // Block is idle once every result is in and the pipe behind the last
  // result-free byte has emptied; only then may registers change.
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (lookup_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, compare, watchdog
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    iskl_result_t exp_r;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_if.valid && out_if.ready) begin
        results_checked++;
        stall_left = idle_en ? $urandom_range(0, 4) : 0;
        if (lookup_results_q.size() == 0) begin
          errors++;
          $error("unexpected result: value_byte %h is_end %b status %0d",
                 out_if.value_byte, out_if.is_end, out_if.status);
        end else begin
          exp_r = lookup_results_q.pop_front();
          if (out_if.value_byte !== exp_r.value_byte) begin
            errors++;
            $error("value_byte: expected %h, got %h", exp_r.value_byte, out_if.value_byte);
          end
          if (out_if.is_end !== exp_r.is_end) begin
            errors++;
            $error("is_end: expected %b, got %b", exp_r.is_end, out_if.is_end);
          end
          if (out_if.status !== exp_r.status) begin
            errors++;
            $error("status: expected %0d, got %0d", exp_r.status, out_if.status);
          end
          if (exp_r.is_end) begin
            status_seen[exp_r.status]++;
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, lookup_results_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: empty key, limit 8192. "\\e" after the skipped leading
  // separator is an empty key followed by value "e".
  task automatic test_reset_defaults();
    send_text("\\\\e", 1'b1);
    send_text("", 1'b1);
  endtask

  // Key "Ab": case-insensitive hit, key cut off by the terminator, value
  // byte extremes and late bytes after the first match.
  task automatic test_basic_lookup();
    wait_drained();
    write_reg(REG_KEY_LENGTH, 2);
    write_reg(REG_KEY_CHARS_A, 64'h6241);
    send_text("\\aB\\v", 1'b1);
    send_text("ab", 1'b1);
    send_text("x\\y\\AB\\", 1'b0);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_text("\\ab\\z", 1'b1);
  endtask

  // Key length above the maximum, and a zero inside the configured key
  task automatic test_special_keys();
    wait_drained();
    write_reg(REG_KEY_LENGTH, 40);
    send_text("Ab\\v", 1'b1);
    wait_drained();
    write_reg(REG_KEY_LENGTH, 3);
    write_reg(REG_KEY_CHARS_A, 64'h00_6241);
    send_text("Abc\\v", 1'b1);
    wait_drained();
    write_reg(REG_KEY_LENGTH, 2);
  endtask

  // Length limit: zero makes everything oversize, small limits trip on
  // short strings, and oversize beats found.
  task automatic test_length_limit();
    wait_drained();
    write_reg(REG_MAX_INFO_LENGTH, 0);
    send_text("", 1'b1);
    wait_drained();
    write_reg(REG_MAX_INFO_LENGTH, 1);
    send_text("", 1'b1);
    send_text("a", 1'b1);
    wait_drained();
    write_reg(REG_MAX_INFO_LENGTH, 4);
    send_text("Ab\\", 1'b1);
    send_text("Ab\\v", 1'b1);
    wait_drained();
    write_reg(REG_MAX_INFO_LENGTH, CFG_DATA_W'(MAX_LEN_RESET));
  endtask

  // Writes to unused indexes must leave every register alone
  task automatic test_unknown_index();
    wait_drained();
    write_reg(REG_UNKNOWN_LO, '1);
    write_reg(REG_UNKNOWN_HI, '1);
    send_text("ab\\q", 1'b1);
  endtask

  task automatic random_config();
    iskl_key_t  words;
    logic [7:0] kb;
    int         pick;
    int         klen;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       klen = 0;
      1:       klen = MAX_KEY_LEN;
      2:       klen = $urandom_range(MAX_KEY_LEN + 1, 63);
      3:       klen = $urandom_range(9, MAX_KEY_LEN);
      default: klen = $urandom_range(1, 8);
    endcase
    for (int i = 0; i < MAX_KEY_LEN; i++) begin
      // mostly letters so that keys can hit; now and then any byte
      kb = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : rand_letter();
      words[i / 8][(i % 8) * 8 +: 8] = kb;
    end
    write_reg(REG_KEY_LENGTH, CFG_DATA_W'(klen));
    write_reg(REG_KEY_CHARS_A, words[0]);
    write_reg(REG_KEY_CHARS_B, words[1]);
    write_reg(REG_KEY_CHARS_C, words[2]);
    write_reg(REG_KEY_CHARS_D, words[3]);
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1:    write_reg(REG_MAX_INFO_LENGTH, CFG_DATA_W'($urandom_range(1, 24)));
      2:       write_reg(REG_MAX_INFO_LENGTH, CFG_DATA_W'(MAX_LEN_TOP));
      3:       write_reg(REG_MAX_INFO_LENGTH, 1);
      4:       write_reg(REG_MAX_INFO_LENGTH, 0);
      5:       write_reg(REG_MAX_INFO_LENGTH, CFG_DATA_W'($urandom_range(25, 65535)));
      default: write_reg(REG_MAX_INFO_LENGTH, CFG_DATA_W'(MAX_LEN_RESET));
    endcase
  endtask

  // A key: half the time the configured one with random case, sometimes one
  // character short or long, otherwise random bytes.
  task automatic send_key();
    int         mode;
    int         n;
    logic [7:0] c;
    mode = $urandom_range(0, 5);
    if (mode <= 2) begin
      n = (key_len_sh > MAX_KEY_LEN) ? MAX_KEY_LEN : key_len_sh;
      if (mode == 2) begin
        n = n + $urandom_range(0, 2) - 1;
        if (n < 0) begin
          n = 0;
        end
      end
      for (int i = 0; i < n; i++) begin
        c = (i < MAX_KEY_LEN) ? key_char_at(5'(i)) : rand_letter();
        if (is_letter(c) && $urandom_range(0, 1)) begin
          c = c ^ 8'h20;
        end else if ($urandom_range(0, 15) == 0) begin
          // bit 5 flip now and then; on a non-letter it must not fold
          c = c ^ 8'h20;
        end
        if (c == 8'h00 || c == SEP_CHAR) begin
          c = 8'h2E;
        end
        send_byte(c);
      end
    end else begin
      n = $urandom_range(0, 6);
      repeat (n) begin
        c = 8'($urandom_range(1, 255));
        send_byte((c == SEP_CHAR) ? 8'hFF : c);
      end
    end
  endtask

  task automatic send_value();
    int         n;
    logic [7:0] c;
    n = $urandom_range(0, 6);
    repeat (n) begin
      c = 8'($urandom_range(1, 255));
      send_byte((c == SEP_CHAR) ? 8'hFF : c);
    end
  endtask

  task automatic random_string();
    int kind;
    int pairs;
    int n;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // noise
      n = $urandom_range(0, 20);
      repeat (n) send_byte(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(0, 1)) begin
        send_byte(SEP_CHAR);
      end
      pairs = $urandom_range(1, 4);
      for (int p = 0; p < pairs; p++) begin
        send_key();
        if (kind == 1 && p == pairs - 1) begin
          break;  // string ends inside a key
        end
        send_byte(SEP_CHAR);
        send_value();
        if (p != pairs - 1 || kind == 2) begin
          send_byte(SEP_CHAR);
        end
      end
    end
    send_byte(8'h00);
  endtask

  task automatic test_random_strings();
    int first;
    int mark;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_BYTES) begin
      wait_drained();
      random_config();
      mark = bytes_sent;
      while (bytes_sent - mark < SETTING_BYTES && bytes_sent - first < RANDOM_BYTES) begin
        random_string();
      end
    end
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.ch     = 8'h00;
    out_if.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_KEY_LENGTH;
    cfg_wdata    = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_basic_lookup();
    test_special_keys();
    test_length_limit();
    test_unknown_index();
    test_random_strings();

    wait_drained();
    repeat (2 * DRAIN_CYCLES) @(negedge clk_i);

    $display("Run covered %0d strings, %0d bytes and %0d checked results over %0d writes.",
             strings_sent, bytes_sent, results_checked, settings_used);
    $display("End statuses: %0d found, %0d not found, %0d oversize; %0d mismatches.",
             status_seen[ST_FOUND], status_seen[ST_NOT_FOUND], status_seen[ST_OVERSIZE],
             errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
